[src/bpq_pkg.sv]
`default_nettype none

package bpq_pkg;

   localparam int LEVELS     = 16;
   localparam int CAPACITY   = 256;
   localparam int ELEM_WIDTH = 32;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LVL_W  = $clog2(LEVELS);

   // fixed field widths of the request and response
   localparam int KIND_W = 2;
   localparam int PRI_W  = 4;
   localparam int STAT_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENQ   = 2'd0,
      KIND_DEQ   = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_SPARE = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_HEAD = 2'd2,
      S_DONE = 2'd3
   } state_type;

endpackage

`default_nettype wire

[src/bucketed_priority_queue_unit.sv]
`default_nettype none

// Bucketed priority queue: one FIFO per priority level, level 0 most urgent.
// Request channel (req_valid/req_ready): kind selects enqueue, dequeue or a
// status query; req_elem and req_priority_req matter for enqueue only.
// Response channel (rsp_valid/rsp_ready): one response per request with the
// status code, the head element and its level after the operation, the
// element count and an empty flag.
// Configuration: csr_wr_en writes the lowest accepted priority; write only
// while no request is in flight.
// After a request is accepted, the steps are: the link memory read issues at
// the accepting edge, then update links and level pointers, read the head
// element from the element memory, load the response register. The next
// request can be accepted in the cycle after the load, so the block takes no
// new request before the last one's response is loaded. The request rate is
// set by the read-then-write of the link memory and the head element read.
// The response register holds a finished result while the next request is
// accepted; if the receiver stalls, the following response waits in the last
// step until the register frees up.
// Reset empties the queue at once; unused link entries follow a fill count,
// so no clearing pass is needed and requests are accepted right after reset.

module bucketed_priority_queue_unit
   import bpq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [ELEM_WIDTH-1:0] req_elem,
   input  wire logic [PRI_W-1:0]      req_priority_req,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [STAT_W-1:0]          rsp_status,
   output logic [ELEM_WIDTH-1:0]      rsp_head_elem,
   output logic [PRI_W-1:0]           rsp_head_priority,
   output logic [CNT_W-1:0]           rsp_count,
   output logic                       rsp_is_empty,
   input  wire logic                  csr_wr_en,
   input  wire logic [PRI_W-1:0]      csr_wr_data
);

   // memories
   logic [ELEM_WIDTH-1:0] elem_mem [CAPACITY];
   logic [ADDR_W-1:0]     link_mem [CAPACITY];
   logic [ELEM_WIDTH-1:0] elem_rd_ff;
   logic [ADDR_W-1:0]     link_rd_ff;

   // level pointers, meaningful only for flagged levels
   logic [ADDR_W-1:0] level_head_ff [LEVELS];
   logic [ADDR_W-1:0] level_tail_ff [LEVELS];

   state_type         state_ff, state_in;
   logic [LEVELS-1:0] map_ff, map_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] free_head_ff, free_head_in;
   logic [PRI_W-1:0]  lowest_ff;

   // request in flight
   logic                  op_enq_ff, op_enq_in;
   logic                  op_deq_ff, op_deq_in;
   status_type            status_ff, status_in;
   logic [ADDR_W-1:0]     node_ff, node_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic                  fresh_ff, fresh_in;
   logic [ELEM_WIDTH-1:0] elem_ff;

   logic             hd_found_ff;
   logic [LVL_W-1:0] hd_lvl_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [ELEM_WIDTH-1:0] rsp_elem_ff;
   logic [PRI_W-1:0]      rsp_pri_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_load;

   logic [LVL_W-1:0]  first_lvl;
   logic              found;
   logic [ADDR_W-1:0] head_first;
   logic [ADDR_W-1:0] tail_lvl;
   logic [ADDR_W-1:0] link_raddr;
   logic              link_we;
   logic [ADDR_W-1:0] link_waddr, link_wdata;
   logic              elem_we;
   logic              head_we, tail_we;
   logic [ADDR_W-1:0] head_wdata;
   logic              req_fire;
   logic              pri_bad;
   logic [ADDR_W-1:0] fresh_next;

   // lowest flagged level
   always_comb begin
      first_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            first_lvl = LVL_W'(i);
         end
      end
   end

   assign found      = |map_ff;
   assign head_first = level_head_ff[first_lvl];
   assign tail_lvl   = level_tail_ff[lvl_ff];
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign pri_bad    = (req_priority_req > lowest_ff) || (32'(req_priority_req) >= LEVELS);
   assign fresh_next = (node_ff == ADDR_W'(CAPACITY - 1)) ? '0 : node_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      map_in       = map_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      free_head_in = free_head_ff;
      op_enq_in    = op_enq_ff;
      op_deq_in    = op_deq_ff;
      status_in    = status_ff;
      node_in      = node_ff;
      lvl_in       = lvl_ff;
      fresh_in     = fresh_ff;
      link_raddr   = free_head_ff;
      link_we      = 1'b0;
      link_waddr   = node_ff;
      link_wdata   = free_head_ff;
      elem_we      = 1'b0;
      head_we      = 1'b0;
      tail_we      = 1'b0;
      head_wdata   = node_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            op_enq_in = 1'b0;
            op_deq_in = 1'b0;
            status_in = STATUS_OK;
            if (req_kind == KIND_ENQ) begin
               link_raddr = free_head_ff;
               node_in    = free_head_ff;
               lvl_in     = LVL_W'(req_priority_req);
               fresh_in   = CNT_W'(free_head_ff) >= fill_ff;
               if (pri_bad) begin
                  status_in = STATUS_RANGE;
               end else if (count_ff >= CNT_W'(CAPACITY)) begin
                  status_in = STATUS_FULL;
               end else begin
                  op_enq_in = 1'b1;
               end
            end else begin
               link_raddr = head_first;
               node_in    = head_first;
               lvl_in     = first_lvl;
               fresh_in   = 1'b0;
               if (req_kind == KIND_DEQ) begin
                  if (!found || count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     op_deq_in = 1'b1;
                  end
               end
            end
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_enq_ff) begin
               free_head_in = fresh_ff ? fresh_next : link_rd_ff;
               elem_we      = 1'b1;
               // append behind the current tail, or start the level
               if (map_ff[lvl_ff]) begin
                  link_we    = 1'b1;
                  link_waddr = tail_lvl;
                  link_wdata = node_ff;
               end else begin
                  head_we        = 1'b1;
                  head_wdata     = node_ff;
                  map_in[lvl_ff] = 1'b1;
               end
               tail_we  = 1'b1;
               count_in = count_ff + 1'b1;
               if (fresh_ff) begin
                  fill_in = fill_ff + 1'b1;
               end
            end else if (op_deq_ff) begin
               if (node_ff == tail_lvl) begin
                  map_in[lvl_ff] = 1'b0;
               end else begin
                  head_we    = 1'b1;
                  head_wdata = link_rd_ff;
               end
               // push the freed node on the free list
               link_we      = 1'b1;
               link_waddr   = node_ff;
               link_wdata   = free_head_ff;
               free_head_in = node_ff;
               count_in     = count_ff - 1'b1;
            end
            state_in = S_HEAD;
         end
         S_HEAD: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         map_ff       <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
         lowest_ff    <= PRI_W'(15);
      end else begin
         state_ff     <= state_in;
         map_ff       <= map_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            lowest_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_enq_ff <= op_enq_in;
         op_deq_ff <= op_deq_in;
         status_ff <= status_in;
         node_ff   <= node_in;
         lvl_ff    <= lvl_in;
         fresh_ff  <= fresh_in;
         elem_ff   <= req_elem;
      end
      if (head_we) begin
         level_head_ff[lvl_ff] <= head_wdata;
      end
      if (tail_we) begin
         level_tail_ff[lvl_ff] <= node_ff;
      end
      if (state_ff == S_HEAD) begin
         hd_found_ff <= found;
         hd_lvl_ff   <= first_lvl;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_elem_ff   <= hd_found_ff ? elem_rd_ff : '0;
         rsp_pri_ff    <= hd_found_ff ? PRI_W'(hd_lvl_ff) : '0;
         rsp_count_ff  <= count_ff;
      end
   end

   // link memory: one read, one write per cycle
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   // element memory: head read after the pointers have settled
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[node_ff] <= elem_ff;
      end
      if (state_ff == S_HEAD) begin
         elem_rd_ff <= elem_mem[head_first];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_head_elem     = rsp_elem_ff;
   assign rsp_head_priority = rsp_pri_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_is_empty      = (rsp_count_ff == '0);

   a_count_map : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (map_ff == '0))
      else $error("element count and level flags disagree");

   a_count_fill : assert property (@(posedge clock) disable iff (reset)
      (count_ff <= fill_ff) && (fill_ff <= CNT_W'(CAPACITY)))
      else $error("more elements queued than nodes allocated");

   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted request did not start");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire
